FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lkwd_pkg.sv
// ----------------------------------------------------------------------------
// Keystream word decrypt package
// Widths and the keystream functions of the shift-register decryptor.
// ----------------------------------------------------------------------------
package lkwd_pkg;

   localparam int unsigned KEY_WIDTH  = 32;
   localparam int unsigned WORD_WIDTH = 16;

   typedef logic [KEY_WIDTH-1:0]  key_type;
   typedef logic [WORD_WIDTH-1:0] word_type;

   // Fixed bit scramble of the shift register.
   function automatic key_type scramble(input key_type k);
      key_type x;
      key_type t;
      x = (k >> 1) ^ k;
      t = ((k >> 15) & 32'h0000_2000) | (k & 32'h0100_0000);
      t = (t >> 1) | (k & 32'h0002_0000);
      t = (t >> 2) | (k & 32'h0000_1000);
      t = (t >> 3) | (((k >> 7) ^ k) & 32'h0008_0000);
      t = (t >> 1) | (((k >> 15) ^ k) & 32'h0000_4000);
      t = (t >> 2) | (k & 32'h0000_2000);
      t = (t >> 2) | (x & 32'h0000_0040) | (k & 32'h0000_0020);
      t = (t >> 1)
        | (((k >> 9) ^ (k << 8)) & 32'h0000_0800)
        | (((k >> 20) ^ (k << 1)) & 32'h0000_0004)
        | (((k << 3) ^ (k >> 16)) & 32'h0000_4000)
        | (((k >> 2) ^ (k >> 16)) & 32'h0000_0080)
        | (((k << 6) ^ (k >> 7)) & 32'h0000_0100)
        | ((k & 32'h0000_0100) << 7);
      return t;
   endfunction

   // Keystream word: scramble bits 23..8 plus the low byte, with bit 0 of
   // the register ORed in, moved up one byte.
   function automatic word_type keystream(input key_type k);
      key_type  s;
      logic [7:0] hi;
      s  = scramble(k);
      hi = s[7:0] | {7'b0, k[0]};
      return s[23:8] + {hi, 8'b0};
   endfunction

   // One step of the shift register, feedback from bits 0, 10, 30 and 31.
   function automatic key_type next_key(input key_type k);
      logic fb;
      fb = k[0] ^ k[10] ^ k[30] ^ k[31];
      return {fb, k[KEY_WIDTH-1:1]};
   endfunction

endpackage

FILE: rtl/lfsr_keystream_word_decrypt.sv
// ----------------------------------------------------------------------------
// Shift-register keystream word decryptor
// Each 16-bit ciphertext word is XORed with a keystream word drawn from a
// 32-bit shift register, which steps once per word. The first word of a
// message, and the first word after one marked last, loads the register from
// the key written on the csr port; a key written mid-message applies at the
// next message start. The block takes one word per clock: the keystream,
// the XOR and the register step are one level of logic between the shift
// register and the result register, and a word is accepted whenever the
// result register is empty or its transfer completes in the same cycle.
// The result is valid in the cycle after its input transfer.
// ----------------------------------------------------------------------------
module lfsr_keystream_word_decrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_cipher_word,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_plain_word,
   output logic        rsp_last_out
);

   lkwd_pkg::key_type  key_seed_ff;
   lkwd_pkg::key_type  key_ff, key_in;
   logic               start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lkwd_pkg::word_type plain_ff, plain_in;
   logic               last_ff, last_in;
   lkwd_pkg::key_type  key_cur;
   logic               req_fire;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign key_cur   = start_ff ? key_seed_ff : key_ff;

   always_comb begin
      key_in       = key_ff;
      start_in     = start_ff;
      plain_in     = plain_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_fire) begin
         key_in       = lkwd_pkg::next_key(key_cur);
         start_in     = req_last;
         plain_in     = req_cipher_word ^ lkwd_pkg::keystream(key_cur);
         last_in      = req_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seed_ff  <= '0;
         key_ff       <= '0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            key_seed_ff <= csr_wr_data;
         end
         key_ff       <= key_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plain_ff <= plain_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_plain_word = plain_ff;
   assign rsp_last_out   = last_ff;

endmodule

FILE: rtl/lkwd_checker.sv
// ----------------------------------------------------------------------------
// Keystream word decrypt checker
// Port-level assertions on the decryptor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [15:0] req_cipher_word,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_plain_word,
   input logic        rsp_last_out
);

   property p_rsp_hold;
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_plain_word) && $stable(rsp_last_out);
   endproperty

   property p_req_hold;
      req_valid && req_stall |=>
         req_valid && $stable(req_cipher_word) && $stable(req_last);
   endproperty

   property p_stall_cause;
      req_stall |-> rsp_valid && rsp_stall;
   endproperty

   property p_req_to_rsp;
      req_valid && !req_stall |=> rsp_valid;
   endproperty

   `ASSERT_CLK(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result changed")
   `ASSERT_CLK(a_req_hold, clock, reset, p_req_hold, "stalled input changed")
   `ASSERT_CLK(a_stall_cause, clock, reset, p_stall_cause, "input stalled while result side free")
   `ASSERT_CLK(a_req_to_rsp, clock, reset, p_req_to_rsp, "input transfer gave no result")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind lfsr_keystream_word_decrypt lkwd_checker u_lkwd_checker (.*);
